FILE: rtl/assert_macros.svh
// assertion macros used by the rtl files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define HPGL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HPGL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hpgl_pkg.sv
// shared types, widths, micro-op codes and the control rom of the gcd / lcm unit
// no dependencies
`default_nettype none

package hpgl_pkg;

  localparam int PERIOD_BITS = 16;
  localparam int HYPER_BITS  = 32;

  // port field widths
  localparam int MODE_W = 4;
  localparam int TPER_W = 16;
  localparam int HYP_W  = 32;
  localparam int BASE_W = 16;

  localparam int K_BITS    = $clog2(HYPER_BITS);
  localparam int CNT_BITS  = $clog2(HYPER_BITS + 1);
  localparam int PROD_BITS = HYPER_BITS + PERIOD_BITS;
  localparam int STEP_BITS = 4;

  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [PERIOD_BITS:0]   rem_t;
  typedef logic [HYPER_BITS-1:0]  hyper_t;
  typedef logic [PROD_BITS-1:0]   prod_t;
  typedef logic [K_BITS-1:0]      k_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [STEP_BITS-1:0]   step_t;
  typedef logic [MODE_W-1:0]      mode_t;
  typedef logic [TPER_W-1:0]      tper_t;
  typedef logic [HYP_W-1:0]       hyp_t;
  typedef logic [BASE_W-1:0]      base_t;

  typedef enum logic [3:0] {
    OP_IDLE      = 4'd0,
    OP_G1_LOAD   = 4'd1,
    OP_GCD_STEP  = 4'd2,
    OP_G1_STORE  = 4'd3,
    OP_G2_LOAD   = 4'd4,
    OP_DIV_LOAD  = 4'd5,
    OP_DIV_STEP  = 4'd6,
    OP_MUL       = 4'd7,
    OP_LCM_UPD   = 4'd8,
    OP_EMIT      = 4'd9,
    OP_NOP       = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_IN    = 3'd2,
    COND_GCD_BUSY = 3'd3,
    COND_CNT_BUSY = 3'd4,
    COND_SKIP_LCM = 3'd5,
    COND_NOT_LAST = 3'd6,
    COND_OUT_FULL = 3'd7
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic gcd_busy;
    logic cnt_busy;
    logic skip_lcm;
    logic not_last;
    logic out_full;
  } status_t;

  localparam step_t S_IDLE     = step_t'(0);
  localparam step_t S_G1_LOAD  = step_t'(1);
  localparam step_t S_G1_STEP  = step_t'(2);
  localparam step_t S_G1_STORE = step_t'(3);
  localparam step_t S_G2_LOAD  = step_t'(4);
  localparam step_t S_G2_STEP  = step_t'(5);
  localparam step_t S_DIV_LOAD = step_t'(6);
  localparam step_t S_DIV_STEP = step_t'(7);
  localparam step_t S_MUL      = step_t'(8);
  localparam step_t S_LCM_UPD  = step_t'(9);
  localparam step_t S_CHK_LAST = step_t'(10);
  localparam step_t S_EMIT     = step_t'(11);
  localparam step_t S_RETURN   = step_t'(12);

  // microprogram: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: S_IDLE};
    case (s)
      S_IDLE:     w = '{op: OP_IDLE,     cond: COND_NO_IN,    target: S_IDLE};
      S_G1_LOAD:  w = '{op: OP_G1_LOAD,  cond: COND_NEVER,    target: S_IDLE};
      S_G1_STEP:  w = '{op: OP_GCD_STEP, cond: COND_GCD_BUSY, target: S_G1_STEP};
      S_G1_STORE: w = '{op: OP_G1_STORE, cond: COND_SKIP_LCM, target: S_CHK_LAST};
      S_G2_LOAD:  w = '{op: OP_G2_LOAD,  cond: COND_NEVER,    target: S_IDLE};
      S_G2_STEP:  w = '{op: OP_GCD_STEP, cond: COND_GCD_BUSY, target: S_G2_STEP};
      S_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: COND_NEVER,    target: S_IDLE};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_CNT_BUSY, target: S_DIV_STEP};
      S_MUL:      w = '{op: OP_MUL,      cond: COND_NEVER,    target: S_IDLE};
      S_LCM_UPD:  w = '{op: OP_LCM_UPD,  cond: COND_NEVER,    target: S_IDLE};
      S_CHK_LAST: w = '{op: OP_NOP,      cond: COND_NOT_LAST, target: S_IDLE};
      S_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FULL, target: S_EMIT};
      S_RETURN:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: S_IDLE};
      default:    w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hpgl_seq.sv
// micro-sequencer: step counter, control rom lookup and conditional jumps
// depends on hpgl_pkg
`default_nettype none

module hpgl_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hpgl_pkg::status_t status,
  output hpgl_pkg::ctrl_t        ctrl
);

  hpgl_pkg::step_t step_r;
  hpgl_pkg::step_t step_nxt;
  logic            take;

  assign ctrl = hpgl_pkg::ucode_rom(step_r);

  always_comb begin
    case (ctrl.cond)
      hpgl_pkg::COND_NEVER:    take = 1'b0;
      hpgl_pkg::COND_ALWAYS:   take = 1'b1;
      hpgl_pkg::COND_NO_IN:    take = status.no_in;
      hpgl_pkg::COND_GCD_BUSY: take = status.gcd_busy;
      hpgl_pkg::COND_CNT_BUSY: take = status.cnt_busy;
      hpgl_pkg::COND_SKIP_LCM: take = status.skip_lcm;
      hpgl_pkg::COND_NOT_LAST: take = status.not_last;
      hpgl_pkg::COND_OUT_FULL: take = status.out_full;
      default:                 take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : hpgl_pkg::step_t'(step_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= hpgl_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpgl_dpath.sv
// datapath: running gcd / lcm state, binary gcd unit, serial divider, multiplier, result register
// depends on hpgl_pkg; driven by the control word of hpgl_seq
`default_nettype none

module hpgl_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hpgl_pkg::ctrl_t   ctrl,
  output hpgl_pkg::status_t      status,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hpgl_pkg::mode_t   in_mode_id,
  input  wire hpgl_pkg::tper_t   in_task_period,
  input  wire logic              in_last_period,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hpgl_pkg::mode_t        out_result_mode,
  output hpgl_pkg::hyp_t         out_hyperperiod,
  output hpgl_pkg::base_t        out_base_unit,
  output logic                   out_overflowed
);

  // captured beat
  hpgl_pkg::mode_t   mode_r;
  hpgl_pkg::period_t p_r;
  logic              last_r;

  // running state of the mode being built
  hpgl_pkg::period_t gcd_r, gcd_nxt;
  hpgl_pkg::hyper_t  lcm_r, lcm_nxt;
  logic              ovf_r, ovf_nxt;

  // work registers
  hpgl_pkg::hyper_t  x_r, x_nxt, y_r, y_nxt;
  hpgl_pkg::k_t      k_r, k_nxt;
  hpgl_pkg::hyper_t  q_r, q_nxt;
  hpgl_pkg::period_t rem_r, rem_nxt, d_r, d_nxt;
  hpgl_pkg::cnt_t    cnt_r, cnt_nxt;
  hpgl_pkg::prod_t   prod_r, prod_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  hpgl_pkg::mode_t   omode_r, omode_nxt;
  hpgl_pkg::hyper_t  ohyp_r, ohyp_nxt;
  hpgl_pkg::period_t obase_r, obase_nxt;
  logic              oovf_r, oovf_nxt;

  logic              in_fire;
  logic              gcd_busy;
  logic              out_full;
  hpgl_pkg::hyper_t  gval;
  hpgl_pkg::rem_t    rem_sh;
  logic              q_bit;

  assign in_ready = (ctrl.op == hpgl_pkg::OP_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign gcd_busy = (x_r != '0) && (y_r != '0);
  assign out_full = out_valid_r && !out_ready;
  // odd part times the common power of two
  assign gval     = hpgl_pkg::hyper_t'((x_r | y_r) << k_r);
  assign rem_sh   = {rem_r, q_r[hpgl_pkg::HYPER_BITS-1]};
  assign q_bit    = (rem_sh >= {1'b0, d_r});

  assign status.no_in    = !in_valid;
  assign status.gcd_busy = gcd_busy;
  assign status.cnt_busy = (cnt_r != '0);
  assign status.skip_lcm = (p_r == '0) || ovf_r;
  assign status.not_last = !last_r;
  assign status.out_full = out_full;

  assign out_valid       = out_valid_r;
  assign out_result_mode = omode_r;
  assign out_hyperperiod = hpgl_pkg::hyp_t'(ohyp_r);
  assign out_base_unit   = hpgl_pkg::base_t'(obase_r);
  assign out_overflowed  = oovf_r;

  always_comb begin
    gcd_nxt       = gcd_r;
    lcm_nxt       = lcm_r;
    ovf_nxt       = ovf_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    omode_nxt     = omode_r;
    ohyp_nxt      = ohyp_r;
    obase_nxt     = obase_r;
    oovf_nxt      = oovf_r;

    case (ctrl.op)
      hpgl_pkg::OP_G1_LOAD: begin
        x_nxt = hpgl_pkg::hyper_t'(p_r);
        y_nxt = hpgl_pkg::hyper_t'(gcd_r);
        k_nxt = '0;
      end
      hpgl_pkg::OP_GCD_STEP: begin
        if (gcd_busy) begin
          case ({x_r[0], y_r[0]})
            2'b00: begin
              x_nxt = x_r >> 1;
              y_nxt = y_r >> 1;
              k_nxt = hpgl_pkg::k_t'(k_r + 1'b1);
            end
            2'b01: x_nxt = x_r >> 1;
            2'b10: y_nxt = y_r >> 1;
            default: begin
              if (x_r >= y_r) begin
                x_nxt = x_r - y_r;
              end else begin
                y_nxt = y_r - x_r;
              end
            end
          endcase
        end
      end
      hpgl_pkg::OP_G1_STORE: gcd_nxt = hpgl_pkg::period_t'(gval);
      hpgl_pkg::OP_G2_LOAD: begin
        x_nxt = lcm_r;
        y_nxt = hpgl_pkg::hyper_t'(p_r);
        k_nxt = '0;
      end
      hpgl_pkg::OP_DIV_LOAD: begin
        // gcd of lcm and period divides the period, so it fits period width
        d_nxt   = hpgl_pkg::period_t'(gval);
        q_nxt   = lcm_r;
        rem_nxt = '0;
        cnt_nxt = hpgl_pkg::cnt_t'(hpgl_pkg::HYPER_BITS);
      end
      hpgl_pkg::OP_DIV_STEP: begin
        if (cnt_r != '0) begin
          rem_nxt = q_bit ? hpgl_pkg::period_t'(rem_sh - {1'b0, d_r})
                          : hpgl_pkg::period_t'(rem_sh);
          q_nxt   = {q_r[hpgl_pkg::HYPER_BITS-2:0], q_bit};
          cnt_nxt = hpgl_pkg::cnt_t'(cnt_r - 1'b1);
        end
      end
      hpgl_pkg::OP_MUL: prod_nxt = hpgl_pkg::prod_t'(q_r) * hpgl_pkg::prod_t'(p_r);
      hpgl_pkg::OP_LCM_UPD: begin
        if (prod_r[hpgl_pkg::PROD_BITS-1:hpgl_pkg::HYPER_BITS] != '0) begin
          lcm_nxt = '1;
          ovf_nxt = 1'b1;
        end else begin
          lcm_nxt = prod_r[hpgl_pkg::HYPER_BITS-1:0];
        end
      end
      hpgl_pkg::OP_EMIT: begin
        if (!out_full) begin
          out_valid_nxt = 1'b1;
          omode_nxt     = mode_r;
          ohyp_nxt      = lcm_r;
          obase_nxt     = gcd_r;
          oovf_nxt      = ovf_r;
          gcd_nxt       = '0;
          lcm_nxt       = hpgl_pkg::hyper_t'(1);
          ovf_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcd_r       <= '0;
      lcm_r       <= hpgl_pkg::hyper_t'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      gcd_r       <= gcd_nxt;
      lcm_r       <= lcm_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode_id;
      p_r    <= hpgl_pkg::period_t'(in_task_period);
      last_r <= in_last_period;
    end
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    k_r     <= k_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    d_r     <= d_nxt;
    prod_r  <= prod_nxt;
    omode_r <= omode_nxt;
    ohyp_r  <= ohyp_nxt;
    obase_r <= obase_nxt;
    oovf_r  <= oovf_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/hyperperiod_gcd_lcm_unit.sv
// Hyperperiod and base-unit builder. Task periods of one scheduling mode arrive one beat at a
// time on the in_ channel, the final one flagged by in_last_period. Each period is folded into
// a running gcd (starts at 0) and a running lcm (starts at 1); on the flagged beat one result
// beat carries the mode id, the lcm as hyperperiod, the gcd as base unit and an overflow flag,
// and the running values return to their start values. An lcm that leaves 32 bits saturates
// to all ones with out_overflowed set; later periods of that mode still refine the gcd. A zero
// period leaves both values unchanged. One beat is worked on at a time by a small microcoded
// sequencer: a binary gcd loop (one shift or subtract per cycle) for the new gcd, a second one
// for gcd(lcm, period), a 32-step restoring divider for lcm / gcd and one registered
// 32x16 multiply. A zero period or a saturated lcm skips the lcm steps. in_ready is high
// only while the sequencer sits at its idle step. The result sits in an output register,
// so the next period is taken while a result still waits for out_ready; only the emit step
// waits if the previous result is untaken.
// depends on hpgl_pkg, hpgl_seq, hpgl_dpath and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hyperperiod_gcd_lcm_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hpgl_pkg::mode_t      in_mode_id,
  input  wire hpgl_pkg::tper_t      in_task_period,
  input  wire logic                 in_last_period,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hpgl_pkg::mode_t           out_result_mode,
  output hpgl_pkg::hyp_t            out_hyperperiod,
  output hpgl_pkg::base_t           out_base_unit,
  output logic                      out_overflowed
);

  // control word from the rom, status flags back from the datapath
  hpgl_pkg::ctrl_t   ctrl;
  hpgl_pkg::status_t status;

  hpgl_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  hpgl_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .status          (status),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode_id      (in_mode_id),
    .in_task_period  (in_task_period),
    .in_last_period  (in_last_period),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_mode (out_result_mode),
    .out_hyperperiod (out_hyperperiod),
    .out_base_unit   (out_base_unit),
    .out_overflowed  (out_overflowed)
  );

  // sequencer leaves idle only on an accepted beat
  `HPGL_ASSERT_NEXT(a_idle_hold, (ctrl.op == hpgl_pkg::OP_IDLE) && !in_valid, ctrl.op == hpgl_pkg::OP_IDLE, "sequencer left idle without a beat")

  // a new result only comes from the emit step
  `HPGL_ASSERT(a_emit_src, $rose(out_valid) |-> $past(ctrl.op == hpgl_pkg::OP_EMIT), "result raised outside emit")

  // lcm never collapses to zero
  `HPGL_ASSERT(a_hyp_nonzero, out_valid |-> (out_hyperperiod != '0), "zero hyperperiod on result")

  // overflow always comes with a saturated hyperperiod
  `HPGL_ASSERT(a_ovf_sat, (out_valid && out_overflowed) |-> (&out_hyperperiod), "overflow without saturation")

endmodule

`default_nettype wire

FILE: tb/hyperperiod_checker.sv
// checker for the hyperperiod / base-unit unit: predicts each result beat from the period beats
// and compares it field by field; depends on hpgl_pkg
`timescale 1ns / 1ps

module hyperperiod_checker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire hpgl_pkg::mode_t in_mode_id,
  input  wire hpgl_pkg::tper_t in_task_period,
  input  wire logic            in_last_period,
  input  wire logic            out_valid,
  input  wire logic            out_ready,
  input  wire hpgl_pkg::mode_t out_result_mode,
  input  wire hpgl_pkg::hyp_t  out_hyperperiod,
  input  wire hpgl_pkg::base_t out_base_unit,
  input  wire logic            out_overflowed,
  output int                   mismatches,
  output int                   awaited
);

  typedef struct packed {
    hpgl_pkg::mode_t mode;
    hpgl_pkg::hyp_t  hyper;
    hpgl_pkg::base_t base;
    logic            ovf;
  } mode_summary_t;

  localparam longint unsigned HYPER_MAX = 64'h0000_0000_FFFF_FFFF;

  mode_summary_t   closed_modes[$];
  longint unsigned gcd_acc;
  longint unsigned lcm_acc;
  logic            lcm_sat;
  int              fail_tally;
  mode_summary_t   got;
  mode_summary_t   want;

  function automatic longint unsigned common_divisor(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // fold one period into the running gcd and lcm
  task automatic fold_period(input hpgl_pkg::tper_t period);
    longint unsigned p;
    longint unsigned g;
    longint unsigned q;
    p = longint'(period);
    gcd_acc = common_divisor(p, gcd_acc);
    // zero periods and a saturated lcm leave the lcm alone
    if (p != 0 && !lcm_sat) begin
      g = common_divisor(lcm_acc, p);
      q = lcm_acc / g;
      if (q > HYPER_MAX / p) begin
        lcm_acc = HYPER_MAX;
        lcm_sat = 1'b1;
      end else begin
        lcm_acc = q * p;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gcd_acc    = 0;
      lcm_acc    = 1;
      lcm_sat    = 1'b0;
      fail_tally = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.mode  = out_result_mode;
        got.hyper = out_hyperperiod;
        got.base  = out_base_unit;
        got.ovf   = out_overflowed;
        if (closed_modes.size() == 0) begin
          $error("result beat for mode %0d with no mode closed", got.mode);
          fail_tally++;
        end else begin
          want = closed_modes.pop_front();
          if (got.mode !== want.mode) begin
            $error("result_mode: expected %0d, got %0d", want.mode, got.mode);
            fail_tally++;
          end
          if (got.hyper !== want.hyper) begin
            $error("hyperperiod: expected %0d, got %0d", want.hyper, got.hyper);
            fail_tally++;
          end
          if (got.base !== want.base) begin
            $error("base_unit: expected %0d, got %0d", want.base, got.base);
            fail_tally++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflowed: expected %0b, got %0b", want.ovf, got.ovf);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fold_period(in_task_period);
        if (in_last_period) begin
          want.mode  = in_mode_id;
          want.hyper = hpgl_pkg::hyp_t'(lcm_acc);
          want.base  = hpgl_pkg::base_t'(gcd_acc);
          want.ovf   = lcm_sat;
          closed_modes.push_back(want);
          gcd_acc = 0;
          lcm_acc = 1;
          lcm_sat = 1'b0;
        end
      end
    end
    mismatches <= fail_tally;
    awaited    <= closed_modes.size();
  end

endmodule

FILE: tb/testbench.sv
// top of the hyperperiod / base-unit testbench: clock, reset, period stimulus and verdict
// depends on hpgl_pkg, hyperperiod_gcd_lcm_unit and hyperperiod_checker
`timescale 1ns / 1ps

module testbench;

  // drain time covers a slow beat; a result may also wait on out_ready
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int RANDOM_BEATS = 1050;
  // beats sent in this window see no idling on either side
  localparam int CALM_FROM    = 400;
  localparam int CALM_TO      = 620;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  hpgl_pkg::mode_t in_mode_id;
  hpgl_pkg::tper_t in_task_period;
  logic            in_last_period;
  logic            out_valid;
  logic            out_ready;
  hpgl_pkg::mode_t out_result_mode;
  hpgl_pkg::hyp_t  out_hyperperiod;
  hpgl_pkg::base_t out_base_unit;
  logic            out_overflowed;

  int              mismatches;
  int              awaited;
  int unsigned     cycle_count = 0;
  int              beats_sent;
  logic            calm;
  hpgl_pkg::tper_t mode_periods[$];

  hyperperiod_gcd_lcm_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode_id      (in_mode_id),
    .in_task_period  (in_task_period),
    .in_last_period  (in_last_period),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_mode (out_result_mode),
    .out_hyperperiod (out_hyperperiod),
    .out_base_unit   (out_base_unit),
    .out_overflowed  (out_overflowed)
  );

  hyperperiod_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode_id      (in_mode_id),
    .in_task_period  (in_task_period),
    .in_last_period  (in_last_period),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_mode (out_result_mode),
    .out_hyperperiod (out_hyperperiod),
    .out_base_unit   (out_base_unit),
    .out_overflowed  (out_overflowed),
    .mismatches      (mismatches),
    .awaited         (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[hyperperiod_gcd_lcm_unit] ERROR");
      $finish;
    end
  end

  // one period beat; valid drops only when a random gap is taken, so back-to-back
  // beats keep valid high and only the payload changes
  task automatic send_period(input hpgl_pkg::mode_t mode, input hpgl_pkg::tper_t period,
                             input logic last);
    int gap;
    if (!calm && $urandom_range(99) < 38) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode_id     <= mode;
    in_task_period <= period;
    in_last_period <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    calm <= (beats_sent >= CALM_FROM) && (beats_sent < CALM_TO);
  endtask

  // all queued periods as one mode, the mark on the final one
  task automatic run_mode(input hpgl_pkg::mode_t mode);
    for (int i = 0; i < mode_periods.size(); i++)
      send_period(mode, mode_periods[i], i == mode_periods.size() - 1);
  endtask

  // period mix: small values and products of small factors keep the lcm in range, large values
  // push it toward saturation, zeros exercise the no-contribution path
  function automatic hpgl_pkg::tper_t pick_period();
    int kind;
    kind = $urandom_range(99);
    if (kind < 28)      return hpgl_pkg::tper_t'($urandom_range(64, 1));
    else if (kind < 48) return hpgl_pkg::tper_t'($urandom_range(32, 1) * $urandom_range(16, 1));
    else if (kind < 72) return hpgl_pkg::tper_t'($urandom_range(65535, 1));
    else if (kind < 84) return hpgl_pkg::tper_t'($urandom_range(65535, 60000));
    else if (kind < 92) return '0;
    else                return hpgl_pkg::tper_t'($urandom);
  endfunction

  initial begin
    int tasks;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode_id     <= '0;
    in_task_period <= '0;
    in_last_period <= 1'b0;
    out_ready      <= 1'b0;
    calm           <= 1'b0;
    beats_sent     = 0;

    // result side stalls at random outside the calm window
    fork
      forever begin
        @(posedge clk);
        out_ready <= calm || ($urandom_range(99) >= 38);
      end
    join_none

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single smallest and largest periods, extreme mode ids
    mode_periods = '{hpgl_pkg::tper_t'(1)};
    run_mode(hpgl_pkg::mode_t'(0));
    mode_periods = '{hpgl_pkg::tper_t'(16'hFFFF)};
    run_mode(hpgl_pkg::mode_t'(15));
    // mode with only a zero period: base unit 0, hyperperiod 1
    mode_periods = '{hpgl_pkg::tper_t'(0)};
    run_mode(hpgl_pkg::mode_t'(3));
    // zeros mixed in contribute nothing
    mode_periods = '{hpgl_pkg::tper_t'(0), hpgl_pkg::tper_t'(12), hpgl_pkg::tper_t'(0),
                     hpgl_pkg::tper_t'(18)};
    run_mode(hpgl_pkg::mode_t'(5));
    // three large primes saturate the lcm; later periods still fold into the gcd
    mode_periods = '{hpgl_pkg::tper_t'(65521), hpgl_pkg::tper_t'(65519),
                     hpgl_pkg::tper_t'(65497), hpgl_pkg::tper_t'(0),
                     hpgl_pkg::tper_t'(4), hpgl_pkg::tper_t'(2)};
    run_mode(hpgl_pkg::mode_t'(7));
    // an lcm that still fits in 32 bits
    mode_periods = '{hpgl_pkg::tper_t'(32768), hpgl_pkg::tper_t'(16384),
                     hpgl_pkg::tper_t'(16'hFFFF)};
    run_mode(hpgl_pkg::mode_t'(10));
    // alternating bit patterns, one twice the other
    mode_periods = '{hpgl_pkg::tper_t'(16'hAAAA), hpgl_pkg::tper_t'(16'h5555)};
    run_mode(hpgl_pkg::mode_t'(12));
    // harmonic chain: lcm is the largest, gcd the smallest
    mode_periods = '{hpgl_pkg::tper_t'(2), hpgl_pkg::tper_t'(8), hpgl_pkg::tper_t'(128),
                     hpgl_pkg::tper_t'(16'h8000)};
    run_mode(hpgl_pkg::mode_t'(9));
    // the running values must have returned to their start after the mode above
    mode_periods = '{hpgl_pkg::tper_t'(6), hpgl_pkg::tper_t'(10)};
    run_mode(hpgl_pkg::mode_t'(6));

    // random modes, mostly short, now and then long ones
    while (beats_sent < RANDOM_BEATS + 24) begin
      tasks = ($urandom_range(9) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1);
      mode_periods.delete();
      repeat (tasks) mode_periods.push_back(pick_period());
      run_mode(hpgl_pkg::mode_t'($urandom_range(15)));
    end
    in_valid <= 1'b0;

    // drain: every closed mode must produce its result beat
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("[hyperperiod_gcd_lcm_unit] OK");
    end else begin
      $display("[hyperperiod_gcd_lcm_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/hpgl_pkg.sv
rtl/hpgl_seq.sv
rtl/hpgl_dpath.sv
rtl/hyperperiod_gcd_lcm_unit.sv
tb/hyperperiod_checker.sv
tb/testbench.sv
